// File: rtl/dirty_rectangle_detector_defines.svh
// assertion macros shared by the dirty rectangle detector modules
`ifndef DIRTY_RECTANGLE_DETECTOR_DEFINES_SVH
`define DIRTY_RECTANGLE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DRD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dirty rectangle detector: property failed");
`define DRD_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("dirty rectangle detector: forbidden condition");
`else
`define DRD_ASSERT(label, prop)
`define DRD_NEVER(label, cond)
`endif
`endif

// File: rtl/drd_pkg.sv
// shared types and constants of the dirty rectangle detector
`default_nettype none
package drd_pkg;

   localparam int unsigned DEF_MAX_COLUMNS = 256;
   localparam int unsigned DEF_MAX_ROWS    = 256;
   localparam int unsigned SIZE_W          = 9;
   localparam int unsigned MERGE_W         = 8;
   localparam int unsigned COORD_W         = 8;
   localparam int unsigned CELL_W          = 96;
   localparam int unsigned QUEUE_DEPTH     = 4;

   localparam logic [SIZE_W-1:0]  COLUMNS_RESET     = 9'd80;
   localparam logic [SIZE_W-1:0]  ROWS_RESET        = 9'd25;
   localparam logic               USE_SHADOW_RESET  = 1'b1;
   localparam logic [MERGE_W-1:0] MERGE_LIMIT_RESET = 8'd5;

   typedef enum logic [1:0] {
      CSR_COLUMNS     = 2'd0,
      CSR_ROWS        = 2'd1,
      CSR_USE_SHADOW  = 2'd2,
      CSR_MERGE_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  columns;
      logic [SIZE_W-1:0]  rows;
      logic               use_shadow;
      logic [MERGE_W-1:0] merge_limit;
   } cfg_type;

   typedef struct packed {
      logic               frame_last;
      logic [COORD_W-1:0] rect_bottom;
      logic [COORD_W-1:0] rect_right;
      logic [COORD_W-1:0] rect_top;
      logic [COORD_W-1:0] rect_left;
   } rect_type;

   // results of one cell, in order: first, then second
   typedef struct packed {
      logic [1:0] count;
      rect_type   first;
      rect_type   second;
   } emit_type;

endpackage
`default_nettype wire

// File: rtl/drd_tracker.sv
// cell position, running bounding box and held rectangle, one cell per cycle on step
`default_nettype none
`include "dirty_rectangle_detector_defines.svh"
module drd_tracker import drd_pkg::*; #(
   parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  wire logic     differs,
   input  wire cfg_type  cfg,
   output emit_type      emit
);

   localparam int unsigned CW = $clog2(MAX_COLUMNS);
   localparam int unsigned RW = $clog2(MAX_ROWS);

   logic [CW-1:0] x_ff, x_in, bl_ff, bl_in, br_ff, br_in, hl_ff, hl_in, hr_ff, hr_in;
   logic [RW-1:0] y_ff, y_in, bt_ff, bt_in, bb_ff, bb_in, ht_ff, ht_in, hb_ff, hb_in;
   logic          box_open_ff, box_open_in, hv_ff, hv_in;

   logic [CW-1:0] cols_m1, l_edge, r_edge;
   logic [RW-1:0] rows_m1;
   logic [CW:0]   br_p1;
   logic          row_end, frame_end, track, hit, close, merge, close_emit;
   logic          near_left, near_right, row_next;
   rect_type      close_rect, held_rect, box_rect, whole_rect;

   // effective size: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (cfg.columns == '0) begin
         cols_m1 = '0;
      end else if (32'(cfg.columns) > MAX_COLUMNS) begin
         cols_m1 = CW'(MAX_COLUMNS - 1);
      end else begin
         cols_m1 = CW'(cfg.columns - 9'd1);
      end
      if (cfg.rows == '0) begin
         rows_m1 = '0;
      end else if (32'(cfg.rows) > MAX_ROWS) begin
         rows_m1 = RW'(MAX_ROWS - 1);
      end else begin
         rows_m1 = RW'(cfg.rows - 9'd1);
      end
   end

   assign row_end   = x_ff >= cols_m1;
   assign frame_end = row_end && (y_ff >= rows_m1);
   assign track     = cfg.use_shadow;
   assign hit       = track && differs;
   assign close     = track && !differs && box_open_ff && (y_ff > bb_ff) && (x_ff >= bl_ff);

   // closed box widened by one column each side, clamped
   assign l_edge = (bl_ff == '0) ? '0 : bl_ff - CW'(1);
   assign br_p1  = {1'b0, br_ff} + (CW+1)'(1);
   assign r_edge = (br_p1 < {1'b0, cols_m1}) ? br_p1[CW-1:0] : cols_m1;

   assign near_left  = (l_edge >= hl_ff) &&
                       (32'(l_edge - hl_ff) < 32'(cfg.merge_limit));
   assign near_right = (hr_ff >= r_edge) &&
                       (32'(hr_ff - r_edge) < 32'(cfg.merge_limit));
   assign row_next   = ({1'b0, hb_ff} + (RW+1)'(1)) == {1'b0, bt_ff};
   assign merge      = hv_ff && row_next && (near_left || near_right);
   assign close_emit = close && !merge && hv_ff;

   always_comb begin
      box_open_in = box_open_ff;
      bl_in = bl_ff;
      bt_in = bt_ff;
      br_in = br_ff;
      bb_in = bb_ff;
      hv_in = hv_ff;
      hl_in = hl_ff;
      ht_in = ht_ff;
      hr_in = hr_ff;
      hb_in = hb_ff;
      if (hit) begin
         if (!box_open_ff) begin
            box_open_in = 1'b1;
            bl_in = x_ff;
            br_in = x_ff;
            bt_in = y_ff;
            bb_in = y_ff;
         end else begin
            if (x_ff < bl_ff) bl_in = x_ff;
            if (x_ff > br_ff) br_in = x_ff;
            if (y_ff < bt_ff) bt_in = y_ff;
            if (y_ff > bb_ff) bb_in = y_ff;
         end
      end
      if (close) begin
         box_open_in = 1'b0;
         if (merge) begin
            hb_in = bb_ff;
            if (l_edge < hl_ff) hl_in = l_edge;
            if (r_edge > hr_ff) hr_in = r_edge;
         end else begin
            hv_in = 1'b1;
            hl_in = l_edge;
            ht_in = bt_ff;
            hr_in = r_edge;
            hb_in = bb_ff;
         end
      end
   end

   always_comb begin
      close_rect.rect_left   = COORD_W'(hl_ff);
      close_rect.rect_top    = COORD_W'(ht_ff);
      close_rect.rect_right  = COORD_W'(hr_ff);
      close_rect.rect_bottom = COORD_W'(hb_ff);
      close_rect.frame_last  = 1'b0;
      held_rect.rect_left    = COORD_W'(hl_in);
      held_rect.rect_top     = COORD_W'(ht_in);
      held_rect.rect_right   = COORD_W'(hr_in);
      held_rect.rect_bottom  = COORD_W'(hb_in);
      held_rect.frame_last   = 1'b0;
      box_rect.rect_left     = COORD_W'(bl_in);
      box_rect.rect_top      = COORD_W'(bt_in);
      box_rect.rect_right    = COORD_W'(br_in);
      box_rect.rect_bottom   = COORD_W'(bb_in);
      box_rect.frame_last    = 1'b0;
      whole_rect.rect_left   = '0;
      whole_rect.rect_top    = '0;
      whole_rect.rect_right  = COORD_W'(cols_m1);
      whole_rect.rect_bottom = COORD_W'(rows_m1);
      whole_rect.frame_last  = 1'b1;
   end

   always_comb begin
      emit.count  = 2'd0;
      emit.first  = close_rect;
      emit.second = held_rect;
      if (step) begin
         if (frame_end && !track) begin
            emit.count = 2'd1;
            emit.first = whole_rect;
         end else if (close_emit) begin
            emit.count = (frame_end && hv_in) ? 2'd2 : 2'd1;
         end else if (frame_end) begin
            if (hv_in) begin
               emit.first  = held_rect;
               emit.second = box_rect;
               emit.count  = box_open_in ? 2'd2 : 2'd1;
            end else if (box_open_in) begin
               emit.first = box_rect;
               emit.count = 2'd1;
            end
         end
         // frame end marks whichever result comes last
         if (frame_end && track) begin
            if (emit.count == 2'd2) begin
               emit.second.frame_last = 1'b1;
            end else if (emit.count == 2'd1) begin
               emit.first.frame_last = 1'b1;
            end
         end
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (frame_end) begin
         x_in = '0;
         y_in = '0;
      end else if (row_end) begin
         x_in = '0;
         y_in = y_ff + RW'(1);
      end else begin
         x_in = x_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         box_open_ff <= 1'b0;
         hv_ff       <= 1'b0;
      end else if (step) begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         box_open_ff <= frame_end ? 1'b0 : box_open_in;
         hv_ff       <= frame_end ? 1'b0 : hv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         bl_ff <= bl_in;
         bt_ff <= bt_in;
         br_ff <= br_in;
         bb_ff <= bb_in;
         hl_ff <= hl_in;
         ht_ff <= ht_in;
         hr_ff <= hr_in;
         hb_ff <= hb_in;
      end
   end

   `DRD_ASSERT(a_box_ordered, box_open_ff |-> ((bl_ff <= br_ff) && (bt_ff <= bb_ff)))
   `DRD_ASSERT(a_frame_wrap, (step && frame_end) |=> ((x_ff == '0) && (y_ff == '0) && !hv_ff && !box_open_ff))
   `DRD_ASSERT(a_close_holds, (step && close && !frame_end) |=> (hv_ff && !box_open_ff))
   `DRD_NEVER(a_two_mid_frame, step && !frame_end && (emit.count == 2'd2))

endmodule
`default_nettype wire

// File: rtl/drd_out_queue.sv
// result queue taking up to two rectangles per cycle and giving one
`default_nettype none
`include "dirty_rectangle_detector_defines.svh"
module drd_out_queue import drd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire emit_type push,
   output logic          room,
   output logic          out_valid,
   input  wire logic     out_ready,
   output rect_type      head
);

   localparam int unsigned IW = $clog2(DEPTH);

   rect_type          entry_ff [DEPTH];
   logic [IW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [IW:0]       count_ff, count_in;
   logic              pop;

   assign out_valid = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // space for the worst case of two results from one cell
   assign room      = 32'(count_ff) + 32'd2 <= DEPTH;

   assign wr_ptr_in = wr_ptr_ff + IW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + IW'(pop);
   assign count_in  = count_ff + (IW+1)'(push.count) - (IW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + IW'(1)] <= push.second;
      end
   end

   `DRD_NEVER(a_count_over, 32'(count_ff) > DEPTH)
   `DRD_ASSERT(a_push_fits, (push.count != 2'd0) |-> ((32'(count_ff) + 32'(push.count)) <= DEPTH))
   `DRD_ASSERT(a_ptr_gap, (wr_ptr_ff - rd_ptr_ff) == IW'(count_ff))

endmodule
`default_nettype wire

// File: rtl/dirty_rectangle_detector.sv
// top level of the dirty rectangle detector: config registers, cell stage, tracker, result queue
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: new_char, new_attr, old_char, old_attr
//   rsp      out  rsp_tvalid/tready     tdata: rect_left, rect_top, rect_right, rect_bottom
//                                       tlast: frame_last
//   csr      in   csr_wr_en             csr_index, csr_wdata
//
// one cell per clock while the result queue has room; cells are registered in the cell
// stage, results in the result queue; the cell stage compares new and old, the tracker
// updates box and held rectangle; a four-entry result queue absorbs two results from one cell
// req_tready drops only while the result queue holds more than two rectangles
// synchronous reset restores register defaults and empties all stages
`default_nettype none
module dirty_rectangle_detector import drd_pkg::*; #(
   parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // new_char [31:0], new_attr [95:32], old_char [127:96], old_attr [191:128]
   input  wire logic [2*CELL_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // rect_left [7:0], rect_top [15:8], rect_right [23:16], rect_bottom [31:24]
   output logic [4*COORD_W-1:0]     rsp_tdata,
   output logic                     rsp_tlast,
   input  wire logic                csr_wr_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [SIZE_W-1:0]   csr_wdata
);

   cfg_type  cfg_ff;
   logic     cell_valid_ff, cell_valid_in, differs_ff, differs_in;
   logic     room, step, req_xfer;
   emit_type emit;
   rect_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns     <= COLUMNS_RESET;
         cfg_ff.rows        <= ROWS_RESET;
         cfg_ff.use_shadow  <= USE_SHADOW_RESET;
         cfg_ff.merge_limit <= MERGE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMNS:     cfg_ff.columns     <= csr_wdata;
            CSR_ROWS:        cfg_ff.rows        <= csr_wdata;
            CSR_USE_SHADOW:  cfg_ff.use_shadow  <= csr_wdata[0];
            CSR_MERGE_LIMIT: cfg_ff.merge_limit <= csr_wdata[MERGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign step       = cell_valid_ff && room;
   assign req_tready = !cell_valid_ff || room;
   assign req_xfer   = req_tvalid && req_tready;
   // char and attr of each frame sit side by side, so one wide compare covers both
   assign differs_in = req_tdata[CELL_W-1:0] != req_tdata[2*CELL_W-1:CELL_W];

   always_comb begin
      cell_valid_in = cell_valid_ff;
      if (req_xfer) begin
         cell_valid_in = 1'b1;
      end else if (step) begin
         cell_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
      end else begin
         cell_valid_ff <= cell_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         differs_ff <= differs_in;
      end
   end

   drd_tracker #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .differs (differs_ff),
      .cfg     (cfg_ff),
      .emit    (emit)
   );

   drd_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .head      (head)
   );

   assign rsp_tdata = {head.rect_bottom, head.rect_right, head.rect_top, head.rect_left};
   assign rsp_tlast = head.frame_last;

endmodule
`default_nettype wire
